FILE: design/bcg_pkg.sv
// Package for the Barrett constant generator: field widths and fixed constants.
// Used by bcg_norm, bcg_div and barrett_constant_generator. No dependencies.
package bcg_pkg;

    localparam int MOD_PORT_W        = 64;   // width of the modulus ports
    localparam int DEF_MODULUS_WIDTH = 64;   // default working width of q
    localparam int MU_FRAC_BITS      = 35;
    localparam int MU_W              = 37;   // mu field, bits 0..36
    localparam int K_W               = 6;
    localparam int K_OFFSET          = 6;
    localparam int PACKED_W          = MU_W + K_W;
    localparam int MIN_MODULUS       = 32;

endpackage : bcg_pkg

FILE: design/bcg_norm.sv
// Normalizer: shifts q left one bit per cycle while en is high, until its top bit is set, and
// counts the shifts. Depends on bcg_pkg.
module bcg_norm #(
    parameter int MODULUS_WIDTH = bcg_pkg::DEF_MODULUS_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              en,
    input  logic [MODULUS_WIDTH-1:0]          q_in,
    output logic [MODULUS_WIDTH-1:0]          qn,
    output logic [$clog2(MODULUS_WIDTH)-1:0]  shift_cnt,
    output logic                              norm_done
);
    import bcg_pkg::*;

    localparam int SW = $clog2(MODULUS_WIDTH);

    logic [MODULUS_WIDTH-1:0] qn_reg, qn_next;
    logic [SW-1:0]            cnt_reg, cnt_next;

    always_comb
    begin
        qn_next  = qn_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            qn_next  = q_in;
            cnt_next = '0;
        end
        else if (en && !qn_reg[MODULUS_WIDTH-1])
        begin
            qn_next  = {qn_reg[MODULUS_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qn_reg <= qn_next;
    end

    assign qn        = qn_reg;
    assign shift_cnt = cnt_reg;
    assign norm_done = qn_reg[MODULUS_WIDTH-1];

endmodule : bcg_norm

FILE: design/bcg_div.sv
// Restoring divider: floor(2^(W+35) / d) for a normalized divisor d, one
// quotient bit per cycle, 37 quotient bits in all. Depends on bcg_pkg.
module bcg_div #(
    parameter int MODULUS_WIDTH = bcg_pkg::DEF_MODULUS_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [MODULUS_WIDTH-1:0]    divisor,
    output logic [bcg_pkg::MU_W-1:0]    quotient,
    output logic                        done
);
    import bcg_pkg::*;

    localparam int CW = $clog2(MU_W);

    logic [MODULUS_WIDTH-1:0] rem_reg, rem_next;
    logic [MU_W-1:0]          quo_reg, quo_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [MODULUS_WIDTH:0]   rem_dbl;
    logic [MODULUS_WIDTH:0]   diff;

    // numerator 2^(W+35): its part above the 37 quotient bits is 2^(W-2)
    assign rem_dbl = {rem_reg, 1'b0};
    assign diff    = rem_dbl - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = MODULUS_WIDTH'(1) << (MODULUS_WIDTH - 2);
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[MODULUS_WIDTH])
            begin
                rem_next = diff[MODULUS_WIDTH-1:0];
                quo_next = {quo_reg[MU_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_dbl[MODULUS_WIDTH-1:0];
                quo_next = {quo_reg[MU_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(MU_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule : bcg_div

FILE: design/barrett_constant_generator.sv
// Top level of the Barrett constant generator: sequencer and result registers.
// Depends on bcg_pkg, bcg_norm and bcg_div.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+---------------------------
//  in      | modulus                                      | start & !busy accepts item
//  out     | modulus_word packed_word zero_word mu_value  | done high for one cycle
//          | shift_k invalid                              |
//
// One item at a time. A valid modulus is first normalized, its leading zeros
// within MODULUS_WIDTH being shifted out one per cycle by the normalizer, and
// then passes through the bit-serial divider.
// A modulus below 32 gives its zero result in the cycle after accept.
// Reset clears the sequencer; the result strobe cannot be stalled.
module barrett_constant_generator #(
    parameter int MODULUS_WIDTH = bcg_pkg::DEF_MODULUS_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [bcg_pkg::MOD_PORT_W-1:0]  modulus,
    output logic                            busy,
    output logic                            done,
    output logic [bcg_pkg::MOD_PORT_W-1:0]  modulus_word,
    output logic [bcg_pkg::PACKED_W-1:0]    packed_word,
    output logic                            zero_word,
    output logic [bcg_pkg::MU_W-1:0]        mu_value,
    output logic [bcg_pkg::K_W-1:0]         shift_k,
    output logic                            invalid
);
    import bcg_pkg::*;

    localparam int SW = $clog2(MODULUS_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_DIV
    } state_t;

    state_t                   state_reg;
    logic                     done_reg;
    logic [MOD_PORT_W-1:0]    mod_reg;
    logic [MU_W-1:0]          mu_reg;
    logic [K_W-1:0]           k_reg;
    logic                     inv_reg;

    logic [MODULUS_WIDTH-1:0] q_in;
    logic                     accept;
    logic                     too_small;
    logic [MODULUS_WIDTH-1:0] qn;
    logic [SW-1:0]            shift_cnt;
    logic                     norm_done;
    logic                     div_start;
    logic [MU_W-1:0]          quotient;
    logic                     div_done;
    logic [K_W-1:0]           k_calc;

    assign q_in      = modulus[MODULUS_WIDTH-1:0];
    assign accept    = start && (state_reg == ST_IDLE);
    assign too_small = q_in < MODULUS_WIDTH'(MIN_MODULUS);
    assign div_start = (state_reg == ST_NORM) && norm_done;
    // k = bitlength - 6 = (W - 6) - leading zeros
    assign k_calc    = K_W'(MODULUS_WIDTH - K_OFFSET) - K_W'(shift_cnt);

    bcg_norm #(
        .MODULUS_WIDTH(MODULUS_WIDTH)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .en        (state_reg == ST_NORM),
        .q_in      (q_in),
        .qn        (qn),
        .shift_cnt (shift_cnt),
        .norm_done (norm_done)
    );

    bcg_div #(
        .MODULUS_WIDTH(MODULUS_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (qn),
        .quotient (quotient),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            mod_reg   <= '0;
            mu_reg    <= '0;
            k_reg     <= '0;
            inv_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (too_small)
                        begin
                            done_reg <= 1'b1;
                            mod_reg  <= '0;
                            mu_reg   <= '0;
                            k_reg    <= '0;
                            inv_reg  <= 1'b1;
                        end
                        else
                        begin
                            mod_reg   <= MOD_PORT_W'(q_in);
                            state_reg <= ST_NORM;
                        end
                    end
                end
                ST_NORM:
                begin
                    if (norm_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        done_reg  <= 1'b1;
                        mu_reg    <= quotient;
                        k_reg     <= k_calc;
                        inv_reg   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign modulus_word = mod_reg;
    assign packed_word  = {k_reg, mu_reg};
    assign zero_word    = 1'b0;
    assign mu_value     = mu_reg;
    assign shift_k      = k_reg;
    assign invalid      = inv_reg;

endmodule : barrett_constant_generator
